// ===== rtl/psp_pkg.sv =====
// Shared constants, codes and command/status types for the support point core.
package psp_pkg;

   localparam int MAX_POINTS = 64;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int COUNT_W    = $clog2(MAX_POINTS + 1);

   localparam int LANE_W     = 16;
   localparam int VEC_W      = 3 * LANE_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = VEC_W;

   localparam logic [CSR_IDX_W-1:0] CSR_INV_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_Z  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 3'd6;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_QUERY  = 2'd2
   } psp_action_type;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_INV  = 2'd1,
      MODE_DOT  = 2'd2,
      MODE_FWD  = 2'd3
   } psp_mode_type;

   typedef struct packed {
      psp_mode_type       mode;
      logic [1:0]         row;
      logic [ADDR_W-1:0]  addr;
      logic               first;
      logic               append;
      logic               clear;
      logic               capture;
      logic               load;
      logic               empty;
   } psp_cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
   } psp_status_type;

endpackage

// ===== rtl/psp_ctrl.sv =====
// Sequencer for clear, append and the multi-phase support query.
module psp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_action,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  psp_pkg::psp_status_type status,
   output psp_pkg::psp_cmd_type   cmd
);
   import psp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INV,
      ST_DRAIN_INV,
      ST_DOT,
      ST_DRAIN_DOT,
      ST_FWD,
      ST_DRAIN_FWD,
      ST_FINISH
   } state_type;

   state_type          state_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic               empty_ff;
   logic               rsp_valid_ff;

   logic accept;
   logic can_load;
   logic step_last;
   logic dot_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign step_last = (cnt_ff == COUNT_W'(2));
   assign dot_last  = ((cnt_ff + COUNT_W'(1)) == status.count);

   always_comb begin
      cmd       = '0;
      cmd.mode  = MODE_NONE;
      cmd.row   = cnt_ff[1:0];
      cmd.addr  = cnt_ff[ADDR_W-1:0];
      cmd.empty = empty_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_CLEAR:  cmd.clear = 1'b1;
                  ACT_APPEND: cmd.append = 1'b1;
                  ACT_QUERY:  cmd.capture = 1'b1;
                  default:    cmd.capture = 1'b0;
               endcase
            end
         end
         ST_INV: cmd.mode = MODE_INV;
         ST_DOT: begin
            cmd.mode  = MODE_DOT;
            cmd.first = (cnt_ff == '0);
         end
         ST_FWD:    cmd.mode = MODE_FWD;
         ST_FINISH: cmd.load = can_load;
         default:   cmd.mode = MODE_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         empty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !((state_ff == ST_FINISH) && can_load)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (accept && (req_action == ACT_QUERY)) begin
                  empty_ff <= (status.count == '0);
                  state_ff <= (status.count == '0) ? ST_FINISH : ST_INV;
               end
            end
            ST_INV, ST_DRAIN_INV, ST_FWD, ST_DRAIN_FWD: begin
               cnt_ff <= step_last ? '0 : cnt_ff + COUNT_W'(1);
               if (step_last) begin
                  case (state_ff)
                     ST_INV:       state_ff <= ST_DRAIN_INV;
                     ST_DRAIN_INV: state_ff <= ST_DOT;
                     ST_FWD:       state_ff <= ST_DRAIN_FWD;
                     default:      state_ff <= ST_FINISH;
                  endcase
               end
            end
            ST_DOT: begin
               cnt_ff <= dot_last ? '0 : cnt_ff + COUNT_W'(1);
               if (dot_last) begin
                  state_ff <= ST_DRAIN_DOT;
               end
            end
            ST_DRAIN_DOT: begin
               cnt_ff <= step_last ? '0 : cnt_ff + COUNT_W'(1);
               if (step_last) begin
                  state_ff <= ST_FWD;
               end
            end
            ST_FINISH: begin
               if (can_load) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/psp_dpath.sv =====
// Vertex store, config registers, three-lane multiply pipeline and result register.
module psp_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  psp_pkg::psp_cmd_type              cmd,
   output psp_pkg::psp_status_type           status,
   input  logic signed [psp_pkg::LANE_W-1:0] req_vec_x,
   input  logic signed [psp_pkg::LANE_W-1:0] req_vec_y,
   input  logic signed [psp_pkg::LANE_W-1:0] req_vec_z,
   input  logic                              csr_wen,
   input  logic [psp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic signed [psp_pkg::LANE_W-1:0] rsp_support_x,
   output logic signed [psp_pkg::LANE_W-1:0] rsp_support_y,
   output logic signed [psp_pkg::LANE_W-1:0] rsp_support_z,
   output logic                              rsp_no_points,
   output logic                              rsp_store_overflowed
);
   import psp_pkg::*;

   localparam int PROD_W = 2 * LANE_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int FRAC   = 14;
   localparam int SH_W   = SUM_W - FRAC;
   localparam logic [VEC_W-1:0] ROW_X_RESET = VEC_W'(1) << FRAC;
   localparam logic [VEC_W-1:0] ROW_Y_RESET = VEC_W'(1) << (FRAC + LANE_W);
   localparam logic [VEC_W-1:0] ROW_Z_RESET = VEC_W'(1) << (FRAC + 2 * LANE_W);
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC - 1);

   function automatic logic signed [LANE_W-1:0] sat16(input logic signed [SH_W-1:0] v);
      logic fits;
      fits = (v[SH_W-1:LANE_W-1] == '0) || (v[SH_W-1:LANE_W-1] == '1);
      if (fits) begin
         return v[LANE_W-1:0];
      end
      return v[SH_W-1] ? {1'b1, {(LANE_W-1){1'b0}}} : {1'b0, {(LANE_W-1){1'b1}}};
   endfunction

   logic [VEC_W-1:0]   mem [MAX_POINTS];
   logic [COUNT_W-1:0] count_ff;
   logic               ovf_ff;

   logic [VEC_W-1:0] inv_row_ff [3];
   logic [VEC_W-1:0] fwd_row_ff [3];
   logic [VEC_W-1:0] offset_ff;

   logic [VEC_W-1:0]         dir_ff;
   logic signed [LANE_W-1:0] mdir_ff [3];
   logic signed [LANE_W-1:0] res_ff  [3];
   logic [VEC_W-1:0]         best_ff;
   logic signed [SUM_W-1:0]  best_dot_ff;

   logic [VEC_W-1:0] rd_ff;
   psp_mode_type     s1_mode_ff;
   logic [1:0]       s1_row_ff;
   logic             s1_first_ff;

   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [LANE_W-1:0] bias_ff;
   logic [VEC_W-1:0]         s2_vert_ff;
   psp_mode_type             s2_mode_ff;
   logic [1:0]               s2_row_ff;
   logic                     s2_first_ff;

   logic signed [LANE_W-1:0] op_a [3];
   logic signed [LANE_W-1:0] op_b [3];
   logic [VEC_W-1:0]         row_sel;
   logic signed [SUM_W-1:0]  acc;
   logic signed [SUM_W-1:0]  rounded;
   logic signed [LANE_W-1:0] sat_val;

   logic signed [LANE_W-1:0] sx_ff, sy_ff, sz_ff;
   logic                     np_ff, so_ff;

   assign status.count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         inv_row_ff[0] <= ROW_X_RESET;
         inv_row_ff[1] <= ROW_Y_RESET;
         inv_row_ff[2] <= ROW_Z_RESET;
         fwd_row_ff[0] <= ROW_X_RESET;
         fwd_row_ff[1] <= ROW_Y_RESET;
         fwd_row_ff[2] <= ROW_Z_RESET;
         offset_ff     <= '0;
      end else begin
         if (cmd.clear) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end else if (cmd.append) begin
            if (count_ff < COUNT_W'(MAX_POINTS)) begin
               count_ff <= count_ff + COUNT_W'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (csr_wen) begin
            case (csr_index)
               CSR_INV_X:  inv_row_ff[0] <= csr_wdata;
               CSR_INV_Y:  inv_row_ff[1] <= csr_wdata;
               CSR_INV_Z:  inv_row_ff[2] <= csr_wdata;
               CSR_FWD_X:  fwd_row_ff[0] <= csr_wdata;
               CSR_FWD_Y:  fwd_row_ff[1] <= csr_wdata;
               CSR_FWD_Z:  fwd_row_ff[2] <= csr_wdata;
               CSR_OFFSET: offset_ff     <= csr_wdata;
               default:    offset_ff     <= offset_ff;
            endcase
         end
      end
   end

   // vertex store with one write port and one read port, registered read
   always_ff @(posedge clock) begin
      if (cmd.append && (count_ff < COUNT_W'(MAX_POINTS))) begin
         mem[count_ff[ADDR_W-1:0]] <= {req_vec_z, req_vec_y, req_vec_x};
      end
      rd_ff <= mem[cmd.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_mode_ff <= MODE_NONE;
         s2_mode_ff <= MODE_NONE;
      end else begin
         s1_mode_ff <= cmd.mode;
         s2_mode_ff <= s1_mode_ff;
      end
   end

   // stage 2 operand select
   always_comb begin
      case (s1_row_ff)
         2'd0:    row_sel = (s1_mode_ff == MODE_INV) ? inv_row_ff[0] : fwd_row_ff[0];
         2'd1:    row_sel = (s1_mode_ff == MODE_INV) ? inv_row_ff[1] : fwd_row_ff[1];
         default: row_sel = (s1_mode_ff == MODE_INV) ? inv_row_ff[2] : fwd_row_ff[2];
      endcase
      for (int j = 0; j < 3; j++) begin
         case (s1_mode_ff)
            MODE_INV: begin
               op_a[j] = row_sel[LANE_W*j +: LANE_W];
               op_b[j] = dir_ff[LANE_W*j +: LANE_W];
            end
            MODE_FWD: begin
               op_a[j] = row_sel[LANE_W*j +: LANE_W];
               op_b[j] = best_ff[LANE_W*j +: LANE_W];
            end
            default: begin
               op_a[j] = rd_ff[LANE_W*j +: LANE_W];
               op_b[j] = mdir_ff[j];
            end
         endcase
      end
   end

   // stage 3 sum, round and saturate
   always_comb begin
      acc = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2])
            + (SUM_W'(bias_ff) <<< FRAC);
      rounded = acc + ROUND_HALF;
      sat_val = sat16(rounded[SUM_W-1:FRAC]);
   end

   always_ff @(posedge clock) begin
      s1_row_ff   <= cmd.row;
      s1_first_ff <= cmd.first;
      if (cmd.capture) begin
         dir_ff <= {req_vec_z, req_vec_y, req_vec_x};
      end

      for (int j = 0; j < 3; j++) begin
         prod_ff[j] <= op_a[j] * op_b[j];
      end
      bias_ff     <= (s1_mode_ff == MODE_FWD) ? offset_ff[{s1_row_ff, 4'b0000} +: LANE_W] : '0;
      s2_vert_ff  <= rd_ff;
      s2_row_ff   <= s1_row_ff;
      s2_first_ff <= s1_first_ff;

      case (s2_mode_ff)
         MODE_INV: mdir_ff[s2_row_ff] <= sat_val;
         MODE_FWD: res_ff[s2_row_ff] <= sat_val;
         MODE_DOT: begin
            if (s2_first_ff || (acc > best_dot_ff)) begin
               best_dot_ff <= acc;
               best_ff     <= s2_vert_ff;
            end
         end
         default: best_dot_ff <= best_dot_ff;
      endcase

      if (cmd.load) begin
         sx_ff <= cmd.empty ? '0 : res_ff[0];
         sy_ff <= cmd.empty ? '0 : res_ff[1];
         sz_ff <= cmd.empty ? '0 : res_ff[2];
         np_ff <= cmd.empty;
         so_ff <= ovf_ff;
      end
   end

   assign rsp_support_x        = sx_ff;
   assign rsp_support_y        = sy_ff;
   assign rsp_support_z        = sz_ff;
   assign rsp_no_points        = np_ff;
   assign rsp_store_overflowed = so_ff;

endmodule

// ===== rtl/polytope_support_point_core.sv =====
// Top level of the convex polytope support point core.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  request  | req_action, req_vec_x/y/z               | req_valid, req_stall
//  response | rsp_support_x/y/z, rsp_no_points,       | rsp_valid, rsp_stall
//           | rsp_store_overflowed                    |
//  csr      | csr_index, csr_wdata                    | csr_wen, no stall
//
// Clear and append act on acceptance; a query on an empty store skips to its finish.
// A query with N stored vertices runs three inverse rows, then one vertex per cycle
// through the store's single read port, then three forward rows, each phase
// draining the three-stage shared multiply pipeline.
// Synchronous active-high reset clears count, overflow flag and matrices to identity.
// The next item is taken while a result waits; a query stalls at its end until
// the response register is free.
module polytope_support_point_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic signed [psp_pkg::LANE_W-1:0] req_vec_x,
   input  logic signed [psp_pkg::LANE_W-1:0] req_vec_y,
   input  logic signed [psp_pkg::LANE_W-1:0] req_vec_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [psp_pkg::LANE_W-1:0] rsp_support_x,
   output logic signed [psp_pkg::LANE_W-1:0] rsp_support_y,
   output logic signed [psp_pkg::LANE_W-1:0] rsp_support_z,
   output logic                              rsp_no_points,
   output logic                              rsp_store_overflowed,
   input  logic                              csr_wen,
   input  logic [psp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import psp_pkg::*;

   psp_cmd_type    cmd;
   psp_status_type status;

   psp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   psp_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_vec_x            (req_vec_x),
      .req_vec_y            (req_vec_y),
      .req_vec_z            (req_vec_z),
      .csr_wen              (csr_wen),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_support_x        (rsp_support_x),
      .rsp_support_y        (rsp_support_y),
      .rsp_support_z        (rsp_support_z),
      .rsp_no_points        (rsp_no_points),
      .rsp_store_overflowed (rsp_store_overflowed)
   );

endmodule
